// ===== src/lct_pkg.sv =====
// ----------------------------------------------------------------------------
// lct_pkg: shared types and constants of the min line tree
// operation codes, controller states and the empty line value
// ----------------------------------------------------------------------------
package lct_pkg;

	typedef enum logic [1:0] {
		FN_INSERT = 2'd0,
		FN_QUERY  = 2'd1,
		FN_ADD    = 2'd2,
		FN_CLEAR  = 2'd3
	} func_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD,
		ST_EV_S,
		ST_EV_E,
		ST_EV_M,
		ST_DEC,
		ST_Q_EV,
		ST_Q_DEC,
		ST_FIN,
		ST_OUT
	} state_t;

	localparam logic signed [63:0] EMPTY_Y = 64'sd1000000000000000000;

endpackage

// ===== src/li_chao_min_line_tree.sv =====
// ----------------------------------------------------------------------------
// li_chao_min_line_tree: minimum line container over an integer x domain
// node pool in one synchronous memory, walked one level at a time through read, evaluate and decide cycles
// ----------------------------------------------------------------------------
// One operation at a time. An insert walks from the root, one level at a
// time (node read, three line evaluations at start, end and midpoint, then
// the write back). A query reads, evaluates at x and picks a child per
// level. Offset add and clear skip the walk; clear only resets the fill
// count and the root valid flag, so no node sweep is needed. The walk is set
// by the single read port of the node memory and the shared line evaluator.
module li_chao_min_line_tree #(
	parameter int X_BITS     = 20,
	parameter int NODE_COUNT = 4096
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [1:0]                          func,
	input  logic signed [62:0]                  line_intercept,
	input  logic signed [31:0]                  line_slope,
	input  logic [X_BITS-1:0]                   x_point,
	input  logic signed [62:0]                  offset_delta,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [63:0]                  min_value,
	output logic                                pool_overflow,
	output logic [$clog2(NODE_COUNT + 1)-1:0]   nodes_used,
	output logic                                status
);

	localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
	localparam int CW = $clog2(NODE_COUNT + 1);
	localparam logic [X_BITS-1:0] DMAX = {X_BITS{1'b1}};

	typedef struct packed {
		logic signed [63:0] icpt;
		logic signed [31:0] slope;
		logic [X_BITS-1:0]  lo_x;
		logic [X_BITS-1:0]  hi_x;
		logic [AW-1:0]      left;
		logic [AW-1:0]      right;
	} node_t;

	node_t mem [NODE_COUNT];
	node_t rd_q;
	logic  mem_we;
	logic [AW-1:0] mem_wa;
	node_t mem_wd;
	logic [AW-1:0] rd_addr;

	lct_pkg::state_t state_q, state_d;
	logic [1:0] func_q;
	logic signed [63:0] gi_q;
	logic signed [31:0] gs_q;
	logic [X_BITS-1:0]  x_q;
	logic signed [62:0] delta_q;
	logic [AW-1:0]      node_q;
	logic [CW-1:0]      used_q;
	logic signed [63:0] off_q;
	logic signed [65:0] best_q;
	logic               ovf_q;
	logic               root_vld_q; // root reads as empty line after reset or clear
	node_t              nd_q;
	logic               swap_q;
	logic               fin_e_q;
	logic signed [65:0] ea_q, eb_q;
	logic signed [63:0] res_q;

	// node read, registered
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_q <= mem[rd_addr];
	end

	node_t cur;
	always_comb begin
		cur = rd_q;
		if (node_q == '0 && !root_vld_q) begin
			cur.icpt  = lct_pkg::EMPTY_Y;
			cur.slope = '0;
			cur.lo_x  = '0;
			cur.hi_x  = DMAX;
			cur.left  = '0;
			cur.right = '0;
		end
	end

	logic [X_BITS:0] mid_w;
	assign mid_w = ({1'b0, nd_q.lo_x} + {1'b0, nd_q.hi_x}) >> 1;

	// shared evaluator: both lines at one x, combinational
	logic [X_BITS-1:0] ev_x;
	logic signed [63:0] a_i, b_i;
	logic signed [31:0] a_s, b_s;
	logic signed [X_BITS+32:0] pa, pb;
	logic signed [65:0] va, vb;
	always_comb begin
		a_i = nd_q.icpt;
		a_s = nd_q.slope;
		b_i = gi_q;
		b_s = gs_q;
		if (swap_q) begin
			a_i = gi_q; a_s = gs_q; b_i = nd_q.icpt; b_s = nd_q.slope;
		end
		unique case (state_q)
			lct_pkg::ST_EV_S: begin
				ev_x = nd_q.lo_x;
				a_i = nd_q.icpt; a_s = nd_q.slope; b_i = gi_q; b_s = gs_q;
			end
			lct_pkg::ST_EV_E: ev_x = nd_q.hi_x;
			lct_pkg::ST_EV_M: ev_x = mid_w[X_BITS-1:0];
			default:          ev_x = x_q;
		endcase
		pa = a_s * $signed({1'b0, ev_x});
		pb = b_s * $signed({1'b0, ev_x});
		va = 66'(a_i) + 66'(pa);
		vb = 66'(b_i) + 66'(pb);
	end

	logic signed [65:0] sum_w;
	assign sum_w = best_q + 66'(off_q);

	logic signed [64:0] oadd_w;
	assign oadd_w = 65'(off_q) + 65'(delta_q);

	logic go_right_w;
	assign go_right_w = ea_q < eb_q;
	logic [AW-1:0] child_w;
	assign child_w = go_right_w ? nd_q.right : nd_q.left;
	logic full_w;
	assign full_w = used_q >= CW'(NODE_COUNT);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lct_pkg::ST_IDLE: if (in_valid) begin
				unique case (lct_pkg::func_t'(func))
					lct_pkg::FN_INSERT, lct_pkg::FN_QUERY: state_d = lct_pkg::ST_RD;
					default: state_d = lct_pkg::ST_FIN;
				endcase
			end
			lct_pkg::ST_RD:
				state_d = (func_q == lct_pkg::FN_QUERY) ? lct_pkg::ST_Q_EV : lct_pkg::ST_EV_S;
			lct_pkg::ST_EV_S: state_d = lct_pkg::ST_EV_E;
			lct_pkg::ST_EV_E: state_d = lct_pkg::ST_EV_M;
			lct_pkg::ST_EV_M: state_d = lct_pkg::ST_DEC;
			lct_pkg::ST_DEC: begin
				if (fin_e_q || (child_w == '0 && full_w)) state_d = lct_pkg::ST_FIN;
				else state_d = lct_pkg::ST_RD;
			end
			lct_pkg::ST_Q_EV: state_d = lct_pkg::ST_Q_DEC;
			lct_pkg::ST_Q_DEC: begin
				if (({1'b0, x_q} <= mid_w ? nd_q.left : nd_q.right) == '0)
					state_d = lct_pkg::ST_FIN;
				else state_d = lct_pkg::ST_RD;
			end
			lct_pkg::ST_FIN: state_d = lct_pkg::ST_OUT;
			lct_pkg::ST_OUT: if (!out_stall) state_d = lct_pkg::ST_IDLE;
			default: state_d = lct_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall  = state_q != lct_pkg::ST_IDLE;
		out_valid = state_q == lct_pkg::ST_OUT;
		rd_addr   = node_q;
		mem_we    = 1'b0;
		mem_wa    = node_q;
		mem_wd    = nd_q;
		// read address runs one step ahead so the node is there in ST_RD
		if (state_q == lct_pkg::ST_IDLE) begin
			rd_addr = '0;
		end else if (state_q == lct_pkg::ST_Q_DEC) begin
			rd_addr = ({1'b0, x_q} <= mid_w) ? nd_q.left : nd_q.right;
		end else if (state_q == lct_pkg::ST_DEC) begin
			rd_addr = child_w;
			mem_we = 1'b1;
			if (fin_e_q) begin
				if (swap_q) begin
					mem_wd.icpt = gi_q; mem_wd.slope = gs_q;
				end
			end else begin
				if (go_right_w == swap_q) begin
					mem_wd.icpt = gi_q; mem_wd.slope = gs_q;
				end
				if (child_w == '0 && !full_w) begin
					if (go_right_w) mem_wd.right = used_q[AW-1:0];
					else mem_wd.left = used_q[AW-1:0];
				end
			end
		end
	end

	// a freshly allocated child takes its empty record from a register
	logic init_q;
	node_t init_d_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= lct_pkg::ST_IDLE;
			used_q     <= CW'(1);
			off_q      <= '0;
			root_vld_q <= 1'b0;
			node_q     <= '0;
			init_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				lct_pkg::ST_IDLE: if (in_valid) begin
					node_q <= '0;
					if (lct_pkg::func_t'(func) == lct_pkg::FN_CLEAR) begin
						used_q     <= CW'(1);
						root_vld_q <= 1'b0;
					end
				end
				lct_pkg::ST_DEC: begin
					if (node_q == '0) root_vld_q <= 1'b1;
					if (!fin_e_q && !(child_w == '0 && full_w)) begin
						if (child_w == '0) begin
							node_q <= used_q[AW-1:0];
							used_q <= used_q + CW'(1);
							init_q <= 1'b1;
						end else begin
							node_q <= child_w;
						end
					end
				end
				lct_pkg::ST_Q_DEC:
					node_q <= ({1'b0, x_q} <= mid_w) ? nd_q.left : nd_q.right;
				lct_pkg::ST_FIN:
					if (func_q == lct_pkg::FN_ADD) begin
						if (oadd_w[64] != oadd_w[63])
							off_q <= oadd_w[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
						else off_q <= oadd_w[63:0];
					end
				lct_pkg::ST_RD: init_q <= 1'b0;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			lct_pkg::ST_IDLE: if (in_valid) begin
				func_q  <= func;
				gi_q    <= 64'(line_intercept);
				gs_q    <= line_slope;
				x_q     <= x_point;
				delta_q <= offset_delta;
				best_q  <= 66'(lct_pkg::EMPTY_Y);
				ovf_q   <= 1'b0;
				swap_q  <= 1'b0;
			end
			lct_pkg::ST_RD: begin
				nd_q <= init_q ? init_d_q : cur;
				swap_q <= 1'b0;
			end
			lct_pkg::ST_EV_S: swap_q <= va > vb;
			lct_pkg::ST_EV_E: fin_e_q <= va <= vb;
			lct_pkg::ST_EV_M: begin
				ea_q <= va;
				eb_q <= vb;
			end
			lct_pkg::ST_DEC: begin
				if (!fin_e_q) begin
					if (go_right_w == swap_q) begin
						gi_q <= nd_q.icpt; gs_q <= nd_q.slope;
					end
					if (child_w == '0) begin
						if (full_w) ovf_q <= 1'b1;
						init_d_q.icpt  <= lct_pkg::EMPTY_Y;
						init_d_q.slope <= '0;
						init_d_q.left  <= '0;
						init_d_q.right <= '0;
						init_d_q.lo_x  <= go_right_w ? X_BITS'(mid_w + 1'b1) : nd_q.lo_x;
						init_d_q.hi_x  <= go_right_w ? nd_q.hi_x : mid_w[X_BITS-1:0];
					end
				end
			end
			lct_pkg::ST_Q_EV: if (va < best_q) best_q <= va;
			lct_pkg::ST_FIN: begin
				res_q <= '0;
				if (func_q == lct_pkg::FN_QUERY) begin
					if (sum_w[65:63] != {3{sum_w[63]}})
						res_q <= sum_w[65] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
					else res_q <= sum_w[63:0];
				end
			end
			default: ;
		endcase
	end

	assign min_value     = res_q;
	assign pool_overflow = ovf_q;
	assign nodes_used    = used_q;
	assign status        = 1'b0;

	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CW'(NODE_COUNT)) else $error("fill count past pool size");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(min_value))
		else $error("result changed under stall");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input taken while result pending");

endmodule

// ===== bench/li_chao_min_line_tree_tb.sv =====
// ----------------------------------------------------------------------------
// li_chao_min_line_tree_tb: self-checking bench of the min line tree
// every accepted operation is run through a local copy of the tree; each
// result transfer is checked field by field against the oldest prediction
// ----------------------------------------------------------------------------
module li_chao_min_line_tree_tb;

	localparam int                NODES     = 4096;
	localparam int unsigned       DOM_MAX   = 32'h000F_FFFF;
	localparam longint            CYCLE_CAP = 3_000_000;
	localparam logic signed [63:0] I64_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] I64_MIN  = 64'sh8000_0000_0000_0000;
	localparam logic [62:0]       I63_MAX   = 63'h3FFF_FFFF_FFFF_FFFF;
	localparam logic [62:0]       I63_MIN   = 63'h4000_0000_0000_0000;

	typedef struct packed {
		logic signed [63:0] min_value;
		logic               pool_overflow;
		logic [12:0]        nodes_used;
		logic               status;
	} tree_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         func = '0;
	logic signed [62:0] line_intercept = '0;
	logic signed [31:0] line_slope = '0;
	logic [19:0]        x_point = '0;
	logic signed [62:0] offset_delta = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [63:0] min_value;
	logic               pool_overflow;
	logic [12:0]        nodes_used;
	logic               status;

	// local copy of the tree
	longint      nd_icpt [NODES];
	longint      nd_slope[NODES];
	int unsigned nd_lo   [NODES];
	int unsigned nd_hi   [NODES];
	int unsigned nd_left [NODES];
	int unsigned nd_right[NODES];
	int unsigned tree_fill;
	longint      tree_offset;

	// predictions waiting for their result transfer, oldest at pred_rd
	tree_result_t pred_fifo [16];
	int unsigned  pred_wr = 0;
	int unsigned  pred_rd = 0;
	int           errors = 0;
	longint       cycles = 0;
	int           stall_left = 0;
	int           long_hold_left = 0;
	bit           calm = 0;

	li_chao_min_line_tree dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.func(func), .line_intercept(line_intercept), .line_slope(line_slope),
		.x_point(x_point), .offset_delta(offset_delta),
		.out_valid(out_valid), .out_stall(out_stall),
		.min_value(min_value), .pool_overflow(pool_overflow),
		.nodes_used(nodes_used), .status(status)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("li_chao_min_line_tree_tb failed");
			$finish;
		end
	end

	function automatic logic signed [127:0] line_at(longint ic, longint sl, longint unsigned x);
		logic signed [127:0] a, b, xv;
		a = ic;
		b = sl;
		xv = 0;
		xv[63:0] = x;
		return a + b * xv;
	endfunction

	function automatic longint clamp64(logic signed [127:0] v);
		if (v > I64_MAX) return I64_MAX;
		if (v < I64_MIN) return I64_MIN;
		return v[63:0];
	endfunction

	function automatic void open_node(int unsigned i, int unsigned s, int unsigned e);
		nd_icpt[i] = lct_pkg::EMPTY_Y;
		nd_slope[i] = 0;
		nd_lo[i] = s;
		nd_hi[i] = e;
		nd_left[i] = 0;
		nd_right[i] = 0;
	endfunction

	function automatic void wipe_tree();
		open_node(0, 0, DOM_MAX);
		tree_fill = 1;
	endfunction

	// returns 1 when the losing line had no room in the pool
	function automatic bit push_line(longint gi, longint gs);
		int unsigned n, child;
		longint unsigned s, e, m;
		longint ai, as_, bi, bs, t;
		bit go_right;
		n = 0;
		while (1) begin
			s = nd_lo[n];
			e = nd_hi[n];
			m = (s + e) >> 1;
			ai = nd_icpt[n]; as_ = nd_slope[n]; bi = gi; bs = gs;
			if (line_at(ai, as_, s) > line_at(bi, bs, s)) begin
				t = ai; ai = bi; bi = t;
				t = as_; as_ = bs; bs = t;
			end
			if (line_at(ai, as_, e) <= line_at(bi, bs, e)) begin
				nd_icpt[n] = ai; nd_slope[n] = as_;
				return 0;
			end
			go_right = line_at(ai, as_, m) < line_at(bi, bs, m);
			if (go_right) begin
				nd_icpt[n] = ai; nd_slope[n] = as_;
				gi = bi; gs = bs;
			end else begin
				nd_icpt[n] = bi; nd_slope[n] = bs;
				gi = ai; gs = as_;
			end
			child = go_right ? nd_right[n] : nd_left[n];
			if (child == 0) begin
				if (tree_fill >= NODES) return 1;
				child = tree_fill++;
				if (go_right) begin
					nd_right[n] = child;
					open_node(child, 32'(m + 1), 32'(e));
				end else begin
					nd_left[n] = child;
					open_node(child, 32'(s), 32'(m));
				end
			end
			n = child;
		end
	endfunction

	function automatic longint lowest_at(longint unsigned x);
		logic signed [127:0] best, v, off;
		int unsigned n, nxt;
		longint unsigned m;
		best = lct_pkg::EMPTY_Y;
		n = 0;
		while (1) begin
			m = (longint'(nd_lo[n]) + longint'(nd_hi[n])) >> 1;
			v = line_at(nd_icpt[n], nd_slope[n], x);
			if (v < best) best = v;
			nxt = (x <= m) ? nd_left[n] : nd_right[n];
			if (nxt == 0 || nxt >= NODES) break;
			n = nxt;
		end
		off = tree_offset;
		return clamp64(best + off);
	endfunction

	function automatic tree_result_t apply_op(lct_pkg::func_t f, logic signed [62:0] ic,
			logic signed [31:0] sl, logic [19:0] x, logic signed [62:0] d);
		tree_result_t r;
		logic signed [127:0] a, b;
		r = '0;
		case (f)
			lct_pkg::FN_INSERT: r.pool_overflow = push_line(longint'(ic), longint'(sl));
			lct_pkg::FN_QUERY:  r.min_value = lowest_at(longint'(x));
			lct_pkg::FN_ADD: begin
				a = tree_offset;
				b = d;
				tree_offset = clamp64(a + b);
			end
			default:   wipe_tree();
		endcase
		r.nodes_used = tree_fill[12:0];
		return r;
	endfunction

	task automatic send_op(lct_pkg::func_t f, logic [62:0] ic, logic [31:0] sl,
			logic [19:0] x, logic [62:0] d);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 11);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		func <= f;
		line_intercept <= ic;
		line_slope <= sl;
		x_point <= x;
		offset_delta <= d;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		pred_fifo[pred_wr[3:0]] = apply_op(f, ic, sl, x, d);
		pred_wr++;
	endtask

	function automatic logic [62:0] rand63();
		return 63'({$urandom, $urandom});
	endfunction

	task automatic send_insert(logic [62:0] ic, logic [31:0] sl);
		send_op(lct_pkg::FN_INSERT, ic, sl, 20'($urandom), rand63());
	endtask

	task automatic send_query(logic [19:0] x);
		send_op(lct_pkg::FN_QUERY, rand63(), $urandom, x, rand63());
	endtask

	task automatic send_add(logic [62:0] d);
		send_op(lct_pkg::FN_ADD, rand63(), $urandom, 20'($urandom), d);
	endtask

	task automatic send_clear();
		send_op(lct_pkg::FN_CLEAR, rand63(), $urandom, 20'($urandom), rand63());
	endtask

	// receiver side: per-transfer stall draw, plus an occasional long hold-off
	always @(negedge clk) begin
		if (long_hold_left > 0) begin
			out_stall <= 1'b1;
			long_hold_left--;
		end else if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		tree_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pred_wr == pred_rd) begin
				$error("result transfer with no prediction waiting");
				errors++;
			end else begin
				want = pred_fifo[pred_rd[3:0]];
				pred_rd++;
				if (min_value !== want.min_value) begin
					$error("min_value expected %0d got %0d", want.min_value, min_value);
					errors++;
				end
				if (pool_overflow !== want.pool_overflow) begin
					$error("pool_overflow expected %0d got %0d",
						want.pool_overflow, pool_overflow);
					errors++;
				end
				if (nodes_used !== want.nodes_used) begin
					$error("nodes_used expected %0d got %0d", want.nodes_used, nodes_used);
					errors++;
				end
				if (status !== want.status) begin
					$error("status expected %0d got %0d", want.status, status);
					errors++;
				end
			end
			stall_left = calm ? 0 : $urandom_range(0, 11);
		end
	end

	task automatic test_directed();
		send_query(20'd0);
		send_query(20'hFFFFF);
		send_insert(I63_MAX, 32'h7FFF_FFFF);
		send_insert(I63_MIN, 32'h8000_0000);
		send_query(20'd0);
		send_query(20'hFFFFF);
		send_insert(63'd0, 32'd1);
		send_insert(63'd5, 32'hFFFF_FFFF);
		send_insert(63'd0, 32'd0);
		send_query(20'h7FFFF);
		send_query(20'h80000);
		// offset pushed to the signed limit and held there
		send_add(I63_MAX);
		send_add(I63_MAX);
		send_add(I63_MAX);
		send_query(20'd3);
		send_add(I63_MIN);
		send_add(I63_MIN);
		send_add(I63_MIN);
		send_add(I63_MIN);
		send_add(I63_MIN);
		send_query(20'hFFFFF);
		// clear keeps the offset
		send_clear();
		send_query(20'd12);
		send_add(I63_MAX);
		send_add(I63_MAX);
		send_query(20'd12);
	endtask

	// lines crossing the empty value push the empty line deep, filling the pool
	task automatic test_pool_full();
		longint sl, c;
		send_clear();
		repeat (520) begin
			sl = $urandom_range(1, 1 << 20);
			if ($urandom_range(0, 1)) sl = -sl;
			c = $urandom_range(0, DOM_MAX);
			send_insert(63'(lct_pkg::EMPTY_Y - sl * c), 32'(sl));
			if ($urandom_range(0, 7) == 0) send_query(20'($urandom));
		end
		repeat (20) send_query(20'($urandom));
		send_clear();
	endtask

	task automatic test_long_hold();
		@(posedge clk);
		long_hold_left = 700;
		repeat (6) begin
			send_insert(63'($urandom), $urandom);
			send_query(20'($urandom));
		end
	endtask

	task automatic test_no_idle();
		calm = 1;
		repeat (80) begin
			if ($urandom_range(0, 1)) send_insert(rand63(), $urandom);
			else send_query(20'($urandom));
		end
		calm = 0;
	endtask

	task automatic test_random(int count);
		int op, mode;
		logic [62:0] ic;
		logic [31:0] sl;
		repeat (count) begin
			op = $urandom_range(0, 99);
			if (op < 48) begin
				mode = $urandom_range(0, 3);
				case (mode)
					0: begin
						ic = 63'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
						sl = 32'($signed($urandom_range(0, 2048)) - 1024);
					end
					1: begin
						ic = {{31{$urandom_range(0, 1) == 1}}, 32'($urandom)};
						sl = 32'($signed($urandom_range(0, 1 << 17)) - (1 << 16));
					end
					2: begin
						ic = rand63();
						sl = $urandom;
					end
					default: begin
						ic = 63'(lct_pkg::EMPTY_Y + longint'($signed($urandom)));
						sl = $urandom;
					end
				endcase
				send_insert(ic, sl);
			end else if (op < 92) begin
				send_query($urandom_range(0, 9) == 0 ?
					($urandom_range(0, 1) ? 20'hFFFFF : 20'd0) : 20'($urandom));
			end else if (op < 98) begin
				send_add($urandom_range(0, 3) == 0 ? rand63() :
					63'($signed($urandom_range(0, 2000000)) - 1000000));
			end else begin
				send_clear();
			end
		end
	endtask

	initial begin
		wipe_tree();
		tree_offset = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_pool_full();
		test_long_hold();
		test_no_idle();
		test_random(1200);
		@(negedge clk);
		in_valid <= 1'b0;
		while (pred_wr != pred_rd) @(posedge clk);
		repeat (150) @(posedge clk);
		if (errors == 0) begin
			$display("li_chao_min_line_tree_tb passed");
		end else begin
			$display("li_chao_min_line_tree_tb failed");
		end
		$finish;
	end

endmodule
